// ===== rtl/core/tres_pkg.sv =====
// tres_pkg: shared types and constants for the toy RISC execute step.
// Opcodes, event codes and the register-file write word.
// No dependencies.
`timescale 1ns / 1ps

package tres_pkg;

  localparam int unsigned XLEN   = 32;
  localparam int unsigned NREGS  = 32;
  localparam int unsigned RIDX_W = 5;
  localparam int unsigned OPC_W  = 7;
  localparam int unsigned EV_W   = 3;

  localparam logic [RIDX_W-1:0] REG_ZERO = 5'd0;
  localparam logic [RIDX_W-1:0] REG_RA   = 5'd1;
  localparam logic [RIDX_W-1:0] REG_A0   = 5'd10;
  localparam logic [RIDX_W-1:0] REG_A1   = 5'd11;
  localparam logic [RIDX_W-1:0] REG_A7   = 5'd17;

  localparam logic [XLEN-1:0] SYS_EXIT  = 32'd0;
  localparam logic [XLEN-1:0] SYS_PRINT = 32'd1;
  localparam logic [XLEN-1:0] UPPER_MASK = 32'hffff_f000;
  localparam logic [XLEN-1:0] INSN_STEP  = 32'd4;

  typedef enum logic [OPC_W-1:0] {
    OP_SYSCALL = 7'd1,
    OP_ADD     = 7'd2,
    OP_ADDI    = 7'd3,
    OP_BEQ     = 7'd4,
    OP_BLTU    = 7'd5,
    OP_CALL    = 7'd6,
    OP_RET     = 7'd7,
    OP_JUMP    = 7'd8,
    OP_LI      = 7'd9,
    OP_LUI     = 7'd10,
    OP_MV      = 7'd11
  } opcode_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE    = 3'd0,
    EV_EXIT    = 3'd1,
    EV_PRINT   = 3'd2,
    EV_BADCALL = 3'd3,
    EV_ILLEGAL = 3'd4
  } event_t;

  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

endpackage

// ===== rtl/core/tres_regfile.sv =====
// tres_regfile: 32x32 register file, two registered read ports with write bypass.
// Per-entry valid bits give zero after reset; fixed registers kept as shadow flops.
// Depends on tres_pkg.
`timescale 1ns / 1ps

module tres_regfile (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [tres_pkg::RIDX_W-1:0]   rd_addr_a,
  input  logic [tres_pkg::RIDX_W-1:0]   rd_addr_b,
  input  tres_pkg::rf_wr_t              wr,
  output logic [tres_pkg::XLEN-1:0]     rd_data_a,
  output logic [tres_pkg::XLEN-1:0]     rd_data_b,
  output logic [tres_pkg::XLEN-1:0]     ra_val,
  output logic [tres_pkg::XLEN-1:0]     a0_val,
  output logic [tres_pkg::XLEN-1:0]     a1_val,
  output logic [tres_pkg::XLEN-1:0]     a7_val
);
  import tres_pkg::*;

  logic [XLEN-1:0]  mem_r [NREGS];
  logic [NREGS-1:0] vld_r;
  logic [XLEN-1:0]  q_a_r, q_b_r;
  logic             sel_a_r, sel_b_r;
  logic             byp_a_r, byp_b_r;
  logic [XLEN-1:0]  byp_data_r;
  logic [XLEN-1:0]  ra_r, a0_r, a1_r, a7_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a_r <= mem_r[rd_addr_a];
      q_b_r <= mem_r[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sel_a_r    <= vld_r[rd_addr_a];
      sel_b_r    <= vld_r[rd_addr_b];
      byp_a_r    <= wr.en && (wr.addr == rd_addr_a);
      byp_b_r    <= wr.en && (wr.addr == rd_addr_b);
      byp_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ra_r <= '0;
      a0_r <= '0;
      a1_r <= '0;
      a7_r <= '0;
    end else if (wr.en) begin
      if (wr.addr == REG_RA) ra_r <= wr.data;
      if (wr.addr == REG_A0) a0_r <= wr.data;
      if (wr.addr == REG_A1) a1_r <= wr.data;
      if (wr.addr == REG_A7) a7_r <= wr.data;
    end
  end

  assign rd_data_a = byp_a_r ? byp_data_r : (sel_a_r ? q_a_r : '0);
  assign rd_data_b = byp_b_r ? byp_data_r : (sel_b_r ? q_b_r : '0);
  assign ra_val    = ra_r;
  assign a0_val    = a0_r;
  assign a1_val    = a1_r;
  assign a7_val    = a7_r;

endmodule

// ===== rtl/core/toy_risc_execute_step_top.sv =====
// toy_risc_execute_step_top: single-issue execute step of a toy 32-bit ISA.
// Instruction register, register-file read, combinational execute, result register.
// Depends on tres_pkg and tres_regfile.
//
// Usage:
//   in_*  : one instruction word per transfer, fetched at the last reported
//           out_fetch_address (0 after reset).
//   out_* : exactly one result word per instruction: next fetch address,
//           event code with its arguments, and the halted flag.
// Stages: operand read into the instruction register, then execute into the
//   result register.
// Throughput: 1 instruction per cycle while out_ready is high; register writes of one instruction are
//   forwarded to the operand read of the following one.
// Reset: pc, registers and halted flag cleared; both stages empty.
// Stall: when out_ready is low the result register holds, execute waits, and
//   in_ready drops once the instruction register is also occupied.
// While halted, instructions are consumed with no state change and a result
//   of event 0, zero arguments and halted set.
`timescale 1ns / 1ps

module toy_risc_execute_step_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tres_pkg::XLEN-1:0]   in_instruction,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tres_pkg::XLEN-1:0]   out_fetch_address,
  output logic [tres_pkg::EV_W-1:0]   out_event_kind,
  output logic [tres_pkg::XLEN-1:0]   out_first_argument,
  output logic [tres_pkg::XLEN-1:0]   out_second_argument,
  output logic                        out_halted
);
  import tres_pkg::*;

  logic            ir_valid_r;
  logic [XLEN-1:0] ir_r;
  logic            in_fire, ex_fire;

  logic [XLEN-1:0] pc_r, pc_nxt;
  logic            stop_r, stop_nxt;

  logic [XLEN-1:0] opa, opb, ra_val, a0_val, a1_val, a7_val;
  logic [RIDX_W-1:0] rd_addr_b;
  rf_wr_t          wr;

  logic [OPC_W-1:0] opc;
  logic [XLEN-1:0]  imm12, br_off, jmp_off, seq_pc, tgt_pc, sum;
  logic [EV_W-1:0]  ev;
  logic [XLEN-1:0]  arg1, arg2;

  logic            out_valid_r;
  logic [XLEN-1:0] out_pc_r, out_a1_r, out_a2_r;
  logic [EV_W-1:0] out_ev_r;
  logic            out_halt_r;

  assign ex_fire  = ir_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ir_valid_r || ex_fire;
  assign in_fire  = in_valid && in_ready;

  // port B reads rt for add, rd otherwise (branch compare)
  assign rd_addr_b = (in_instruction[OPC_W-1:0] == OP_ADD) ?
                     in_instruction[21:17] : in_instruction[11:7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else if (in_fire) begin
      ir_valid_r <= 1'b1;
    end else if (ex_fire) begin
      ir_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ir_r <= in_instruction;
    end
  end

  tres_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (in_instruction[16:12]),
    .rd_addr_b (rd_addr_b),
    .wr        (wr),
    .rd_data_a (opa),
    .rd_data_b (opb),
    .ra_val    (ra_val),
    .a0_val    (a0_val),
    .a1_val    (a1_val),
    .a7_val    (a7_val)
  );

  assign opc     = ir_r[OPC_W-1:0];
  assign imm12   = {{20{ir_r[31]}}, ir_r[31:20]};
  assign br_off  = {{19{ir_r[31]}}, ir_r[31:20], 1'b0};
  assign jmp_off = {{11{ir_r[31]}}, ir_r[31:12], 1'b0};
  assign seq_pc  = pc_r + INSN_STEP;
  assign tgt_pc  = pc_r + (((opc == OP_CALL) || (opc == OP_JUMP)) ? jmp_off : br_off);
  assign sum     = opa + ((opc == OP_ADD) ? opb : imm12);

  always_comb begin
    rf_wr_t w;
    w        = '0;
    w.addr   = ir_r[11:7];
    pc_nxt   = seq_pc;
    stop_nxt = stop_r;
    ev       = EV_NONE;
    arg1     = '0;
    arg2     = '0;
    case (opc)
      OP_SYSCALL: begin
        if (a7_val == SYS_EXIT) begin
          ev = EV_EXIT; arg1 = a0_val; stop_nxt = 1'b1;
        end else if (a7_val == SYS_PRINT) begin
          ev = EV_PRINT; arg1 = a0_val; arg2 = a1_val;
        end else begin
          ev = EV_BADCALL; stop_nxt = 1'b1;
        end
      end
      OP_ADD, OP_ADDI: begin
        w.en = 1'b1; w.data = sum;
      end
      OP_BEQ: begin
        if (opb == opa) pc_nxt = tgt_pc;
      end
      OP_BLTU: begin
        if (opb < opa) pc_nxt = tgt_pc;
      end
      OP_CALL: begin
        w.en = 1'b1; w.addr = REG_RA; w.data = seq_pc; pc_nxt = tgt_pc;
      end
      OP_RET:  pc_nxt = ra_val;
      OP_JUMP: pc_nxt = tgt_pc;
      OP_LI: begin
        w.en = 1'b1; w.data = imm12;
      end
      OP_LUI: begin
        w.en = 1'b1; w.data = ir_r & UPPER_MASK;
      end
      OP_MV: begin
        w.en = 1'b1; w.data = opa;
      end
      default: begin
        ev = EV_ILLEGAL; stop_nxt = 1'b1;
      end
    endcase
    if (stop_r) begin
      pc_nxt = pc_r;
      ev     = EV_NONE;
      arg1   = '0;
      arg2   = '0;
      w.en   = 1'b0;
    end
    w.en = w.en && ex_fire && (w.addr != REG_ZERO);
    wr   = w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      stop_r <= 1'b0;
    end else if (ex_fire) begin
      pc_r   <= pc_nxt;
      stop_r <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ex_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_pc_r   <= pc_nxt;
      out_ev_r   <= ev;
      out_a1_r   <= arg1;
      out_a2_r   <= arg2;
      out_halt_r <= stop_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_fetch_address   = out_pc_r;
  assign out_event_kind      = out_ev_r;
  assign out_first_argument  = out_a1_r;
  assign out_second_argument = out_a2_r;
  assign out_halted          = out_halt_r;

endmodule

// ===== rtl/core/tres_checker.sv =====
// tres_checker: port-level assertions for toy_risc_execute_step_top.
// Bound to the top level at the end of this file.
// Depends on tres_pkg.
`timescale 1ns / 1ps

module tres_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tres_pkg::XLEN-1:0]   out_fetch_address,
  input logic [tres_pkg::EV_W-1:0]   out_event_kind,
  input logic [tres_pkg::XLEN-1:0]   out_first_argument,
  input logic [tres_pkg::XLEN-1:0]   out_second_argument,
  input logic                        out_halted
);
  import tres_pkg::*;

  logic seen_halt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_halt_r <= 1'b0;
    end else if (out_valid && out_ready && out_halted) begin
      seen_halt_r <= 1'b1;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seen_halt_r && out_valid |-> out_halted)
    else $error("halted flag dropped after halt");

  a_halt_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_EXIT || out_event_kind == EV_BADCALL ||
                  out_event_kind == EV_ILLEGAL) |-> out_halted)
    else $error("halting event without halted flag");

  a_quiet_args: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != EV_EXIT && out_event_kind != EV_PRINT |->
      out_first_argument == '0 && out_second_argument == '0)
    else $error("arguments set without a call event");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fetch_address))
    else $error("stalled result word changed");

endmodule

bind toy_risc_execute_step_top tres_checker u_tres_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_fetch_address   (out_fetch_address),
  .out_event_kind      (out_event_kind),
  .out_first_argument  (out_first_argument),
  .out_second_argument (out_second_argument),
  .out_halted          (out_halted)
);
